@@ rtl/core/pfi_pkg.sv @@
// ---------------------------------------------------------------------------
// pfi_pkg: shared types for the particle flight integrator
// fixed point word, register codes and the request record
// ---------------------------------------------------------------------------
package pfi_pkg;

   localparam int FIX_W     = 48;
   localparam int CFG_W     = 47;
   localparam int TAG_W     = 16;
   localparam int CSR_IDX_W = 4;

   typedef logic signed [FIX_W-1:0] fix_type;
   typedef logic [CFG_W-1:0]        cfg_word_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TIME_STEP      = 4'd0,
      CSR_GRAVITY_DV     = 4'd1,
      CSR_BUOYANCY_DV    = 4'd2,
      CSR_DRAG_COEFF     = 4'd3,
      CSR_WALL_LIMIT     = 4'd4,
      CSR_SPACE_ALTITUDE = 4'd5,
      CSR_EARTH_RADIUS   = 4'd6,
      CSR_GRAVITY_ENABLE = 4'd7
   } csr_index_type;

   typedef struct packed {
      logic [TAG_W-1:0] idx;
      fix_type          px;
      fix_type          py;
      fix_type          pz;
      fix_type          vx;
      fix_type          vy;
      fix_type          vz;
   } item_type;

endpackage

@@ rtl/core/pfi_interfaces.sv @@
// ---------------------------------------------------------------------------
// pfi interfaces: request, response and register write channels
// valid/ready channels with source and sink views
// ---------------------------------------------------------------------------
interface pfi_req_if;
   import pfi_pkg::*;
   logic             valid;
   logic             ready;
   logic [TAG_W-1:0] particle_index;
   fix_type          pos_x;
   fix_type          pos_y;
   fix_type          pos_z;
   fix_type          vel_x;
   fix_type          vel_y;
   fix_type          vel_z;
   modport source (output valid, particle_index, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                   input ready);
   modport sink (input valid, particle_index, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                 output ready);
endinterface

interface pfi_rsp_if;
   import pfi_pkg::*;
   logic             valid;
   logic             ready;
   logic [TAG_W-1:0] out_index;
   fix_type          new_pos_x;
   fix_type          new_pos_y;
   fix_type          new_pos_z;
   fix_type          new_vel_x;
   fix_type          new_vel_y;
   fix_type          new_vel_z;
   modport source (output valid, out_index, new_pos_x, new_pos_y, new_pos_z,
                   new_vel_x, new_vel_y, new_vel_z, input ready);
   modport sink (input valid, out_index, new_pos_x, new_pos_y, new_pos_z,
                 new_vel_x, new_vel_y, new_vel_z, output ready);
endinterface

interface pfi_csr_if;
   import pfi_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   cfg_word_type         data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/core/pfi_delay.sv @@
// ---------------------------------------------------------------------------
// pfi_delay: stallable delay line
// carries side data alongside the arithmetic units
// ---------------------------------------------------------------------------
module pfi_delay #(
   parameter int W     = 8,
   parameter int DEPTH = 1
) (
   input  logic         clock,
   input  logic         en,
   input  logic [W-1:0] d_in,
   output logic [W-1:0] d_out
);
   logic [W-1:0] tap_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         tap_ff[0] <= d_in;
         for (int i = 1; i < DEPTH; i++) tap_ff[i] <= tap_ff[i-1];
      end
   end

   assign d_out = tap_ff[DEPTH-1];
endmodule

@@ rtl/core/pfi_mul.sv @@
// ---------------------------------------------------------------------------
// pfi_mul: two stage unsigned multiplier
// 32x32 partial products, then a registered sum
// ---------------------------------------------------------------------------
module pfi_mul #(
   parameter int A_W = 48,
   parameter int B_W = 48
) (
   input  logic               clock,
   input  logic               en,
   input  logic [A_W-1:0]     a,
   input  logic [B_W-1:0]     b,
   output logic [A_W+B_W-1:0] prod
);
   localparam int NA    = (A_W + 31) / 32;
   localparam int NB    = (B_W + 31) / 32;
   localparam int SUM_W = (NA + NB) * 32;

   logic [NA*32-1:0]      a_pad;
   logic [NB*32-1:0]      b_pad;
   logic [63:0]           pp_ff [NA][NB];
   logic [SUM_W-1:0]      sum;
   logic [A_W+B_W-1:0]    prod_ff;

   assign a_pad = (NA*32)'(a);
   assign b_pad = (NB*32)'(b);

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < NA; i++)
            for (int j = 0; j < NB; j++)
               pp_ff[i][j] <= 64'(a_pad[i*32 +: 32]) * 64'(b_pad[j*32 +: 32]);
      end
   end

   always_comb begin
      sum = '0;
      for (int i = 0; i < NA; i++)
         for (int j = 0; j < NB; j++)
            sum = sum + (SUM_W'(pp_ff[i][j]) << ((i + j) * 32));
   end

   always_ff @(posedge clock) begin
      if (en) prod_ff <= sum[A_W+B_W-1:0];
   end

   assign prod = prod_ff;
endmodule

@@ rtl/core/pfi_div.sv @@
// ---------------------------------------------------------------------------
// pfi_div: pipelined restoring divider
// one quotient bit per stage, high numerator part must be below the divisor
// ---------------------------------------------------------------------------
module pfi_div #(
   parameter int N_W = 64,
   parameter int D_W = 47,
   parameter int Q_W = 32
) (
   input  logic           clock,
   input  logic           en,
   input  logic [N_W-1:0] num,
   input  logic [D_W-1:0] den,
   output logic [Q_W-1:0] quo
);
   logic [D_W-1:0] rem_s [Q_W+1];
   logic [Q_W-1:0] quo_s [Q_W+1];
   logic [Q_W-1:0] low_s [Q_W+1];
   logic [D_W-1:0] den_s [Q_W+1];

   assign rem_s[0] = D_W'(num[N_W-1:Q_W]);
   assign quo_s[0] = '0;
   assign low_s[0] = num[Q_W-1:0];
   assign den_s[0] = den;

   for (genvar i = 0; i < Q_W; i++) begin : g_step
      logic [D_W:0]   trial;
      logic           take;
      logic [D_W-1:0] rem_ff;
      logic [Q_W-1:0] quo_ff;
      logic [Q_W-1:0] low_ff;
      logic [D_W-1:0] den_ff;

      assign trial = {rem_s[i], low_s[i][Q_W-1]};
      assign take  = trial >= {1'b0, den_s[i]};

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff <= take ? D_W'(trial - {1'b0, den_s[i]}) : trial[D_W-1:0];
            quo_ff <= {quo_s[i][Q_W-2:0], take};
            low_ff <= low_s[i] << 1;
            den_ff <= den_s[i];
         end
      end

      assign rem_s[i+1] = rem_ff;
      assign quo_s[i+1] = quo_ff;
      assign low_s[i+1] = low_ff;
      assign den_s[i+1] = den_ff;
   end

   assign quo = quo_s[Q_W];
endmodule

@@ rtl/core/pfi_sqrt.sv @@
// ---------------------------------------------------------------------------
// pfi_sqrt: pipelined integer square root
// one root bit per stage, floor of the exact root
// ---------------------------------------------------------------------------
module pfi_sqrt #(
   parameter int R_W = 96
) (
   input  logic             clock,
   input  logic             en,
   input  logic [R_W-1:0]   rad,
   output logic [R_W/2-1:0] root
);
   localparam int ROOT_W = R_W / 2;
   localparam int RM_W   = ROOT_W + 1;

   logic [RM_W-1:0]   rem_s  [ROOT_W+1];
   logic [ROOT_W-1:0] root_s [ROOT_W+1];
   logic [R_W-1:0]    rad_s  [ROOT_W+1];

   assign rem_s[0]  = '0;
   assign root_s[0] = '0;
   assign rad_s[0]  = rad;

   for (genvar i = 0; i < ROOT_W; i++) begin : g_step
      logic [RM_W+1:0]   cur;
      logic [RM_W+1:0]   trial;
      logic              take;
      logic [RM_W-1:0]   rem_ff;
      logic [ROOT_W-1:0] root_ff;
      logic [R_W-1:0]    rad_ff;

      assign cur   = {rem_s[i], rad_s[i][R_W-1 -: 2]};
      assign trial = (RM_W+2)'({root_s[i], 2'b01});
      assign take  = cur >= trial;

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff  <= take ? RM_W'(cur - trial) : RM_W'(cur);
            root_ff <= {root_s[i][ROOT_W-2:0], take};
            rad_ff  <= rad_s[i] << 2;
         end
      end

      assign rem_s[i+1]  = rem_ff;
      assign root_s[i+1] = root_ff;
      assign rad_s[i+1]  = rad_ff;
   end

   assign root = root_s[ROOT_W];
endmodule

@@ rtl/core/particle_flight_integrator.sv @@
// ---------------------------------------------------------------------------
// particle_flight_integrator: one integration step per particle
// gravity, bounces, quadratic drag or reduced space gravity, then R += V*dT
// ---------------------------------------------------------------------------
// A fully pipelined block: one request enters per cycle unless a held
// response stalls it, and passes the input register, 86 work stages and the
// output register. The depth is set by the space branch, two bit-serial
// divider pipelines of 32 and 47 stages, in parallel with the 48 stage
// square root pipeline of the drag path. A stalled response freezes the
// whole pipeline; nothing is lost or repeated. Register writes are taken
// at once and must only happen while the pipeline is empty.
module particle_flight_integrator (
   input logic       clock,
   input logic       reset,
   pfi_req_if.sink   req_ch,
   pfi_rsp_if.source rsp_ch,
   pfi_csr_if.sink   csr_ch
);
   import pfi_pkg::*;

   // stage timing, counted from the input register
   localparam int LAT      = 88;
   localparam int T_BASE1  = 83;   // space branch result
   localparam int T_V58    = 54;   // drag path, lane velocities into drag multiply
   localparam int T_DRAG   = 22;   // drag result waits for the space branch
   localparam int T_DIV1   = 32;

   localparam logic signed [50:0] W_MAX = 51'sh0_7FFF_FFFF_FFFF;
   localparam logic signed [50:0] W_MIN = -51'sh0_8000_0000_0000;
   localparam logic [49:0]        STEP_CLAMP = 50'h2_0000_0000_0000;
   localparam logic [15:0]        DAMP_Q16 = 16'd60293;   // 0.92

   typedef struct packed {
      cfg_word_type time_step;
      cfg_word_type gravity_dv;
      cfg_word_type buoyancy_dv;
      cfg_word_type drag_coeff;
      cfg_word_type wall_limit;
      cfg_word_type space_altitude;
      cfg_word_type earth_radius;
      logic         gravity_enable;
   } cfg_type;

   typedef struct packed {
      logic     space;
      item_type item;
   } base_type;

   localparam cfg_type CFG_RESET = '{
      time_step:      47'd655,
      gravity_dv:     47'd6428,
      buoyancy_dv:    47'd0,
      drag_coeff:     47'd0,
      wall_limit:     47'd655360,
      space_altitude: 47'd1392640000,
      earth_radius:   47'd417792000000,
      gravity_enable: 1'b1
   };

   function automatic logic signed [50:0] ext51(input fix_type v);
      ext51 = 51'(v);
   endfunction

   function automatic fix_type sat51(input logic signed [50:0] x);
      if (x > W_MAX) sat51 = W_MAX[47:0];
      else if (x < W_MIN) sat51 = W_MIN[47:0];
      else sat51 = x[47:0];
   endfunction

   function automatic logic [47:0] mag48(input fix_type v);
      mag48 = v[47] ? 48'(-v) : 48'(v);
   endfunction

   // ---------------- registers ----------------
   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_TIME_STEP:      cfg_in.time_step      = csr_ch.data;
            CSR_GRAVITY_DV:     cfg_in.gravity_dv     = csr_ch.data;
            CSR_BUOYANCY_DV:    cfg_in.buoyancy_dv    = csr_ch.data;
            CSR_DRAG_COEFF:     cfg_in.drag_coeff     = csr_ch.data;
            CSR_WALL_LIMIT:     cfg_in.wall_limit     = csr_ch.data;
            CSR_SPACE_ALTITUDE: cfg_in.space_altitude = csr_ch.data;
            CSR_EARTH_RADIUS:   cfg_in.earth_radius   = csr_ch.data;
            CSR_GRAVITY_ENABLE: cfg_in.gravity_enable = csr_ch.data[0];
            default:            cfg_in = cfg_ff;   // unknown index, ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) cfg_ff <= CFG_RESET;
      else cfg_ff <= cfg_in;
   end

   assign csr_ch.ready = 1'b1;

   // ---------------- flow control ----------------
   logic [LAT-1:0] valid_ff;
   logic           advance;

   // whole pipeline moves unless the response register is held
   assign advance      = !valid_ff[LAT-1] || rsp_ch.ready;
   assign req_ch.ready = advance;

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= '0;
      else if (advance) valid_ff <= {valid_ff[LAT-2:0], req_ch.valid};
   end

   // ---------------- input register ----------------
   item_type item0_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         item0_ff.idx <= req_ch.particle_index;
         item0_ff.px  <= req_ch.pos_x;
         item0_ff.py  <= req_ch.pos_y;
         item0_ff.pz  <= req_ch.pos_z;
         item0_ff.vx  <= req_ch.vel_x;
         item0_ff.vy  <= req_ch.vel_y;
         item0_ff.vz  <= req_ch.vel_z;
      end
   end

   // branch select, carried with the record
   logic     space0;
   base_type base0, base83, base86;
   logic [$bits(base_type)-1:0] base83_raw, base86_raw;

   assign space0 = item0_ff.pz > $signed({1'b0, cfg_ff.space_altitude});
   assign base0  = '{space: space0, item: item0_ff};

   pfi_delay #(.W($bits(base_type)), .DEPTH(T_BASE1)) u_base_dly (
      .clock(clock), .en(advance), .d_in(base0), .d_out(base83_raw));
   assign base83 = base83_raw;

   pfi_delay #(.W($bits(base_type)), .DEPTH(3)) u_base_dly2 (
      .clock(clock), .en(advance), .d_in(base83_raw), .d_out(base86_raw));
   assign base86 = base86_raw;

   // ---------------- lower branch: gravity, buoyancy ----------------
   logic signed [50:0] vz1_sum, vz2_sum;
   fix_type            vz2;
   fix_type            l1_vz_ff;
   item_type           l1_item_ff;

   assign vz1_sum = item0_ff.pz[47] ? ext51(item0_ff.vz) + $signed({4'b0, cfg_ff.gravity_dv})
                                    : ext51(item0_ff.vz) - $signed({4'b0, cfg_ff.gravity_dv});

   always_ff @(posedge clock) begin
      if (advance) begin
         l1_vz_ff   <= cfg_ff.gravity_enable ? sat51(vz1_sum) : item0_ff.vz;
         l1_item_ff <= item0_ff;
      end
   end

   // bounce tests: ground in z, side walls in x and y
   logic signed [48:0] wall_p, wall_n, px_e, py_e;
   fix_type            l2_v_ff    [3];
   logic [2:0]         l2_refl_ff;

   assign vz2_sum = ext51(l1_vz_ff) + $signed({4'b0, cfg_ff.buoyancy_dv});
   assign vz2     = cfg_ff.gravity_enable ? sat51(vz2_sum) : l1_vz_ff;
   assign wall_p  = $signed({2'b0, cfg_ff.wall_limit});
   assign wall_n  = -wall_p;
   assign px_e    = 49'(l1_item_ff.px);
   assign py_e    = 49'(l1_item_ff.py);

   always_ff @(posedge clock) begin
      if (advance) begin
         l2_v_ff[0]    <= l1_item_ff.vx;
         l2_v_ff[1]    <= l1_item_ff.vy;
         l2_v_ff[2]    <= vz2;
         l2_refl_ff[0] <= cfg_ff.gravity_enable &&
                          ((px_e > wall_p && l1_item_ff.vx > 48'sd0) ||
                           (px_e < wall_n && l1_item_ff.vx < 48'sd0));
         l2_refl_ff[1] <= cfg_ff.gravity_enable &&
                          ((py_e > wall_p && l1_item_ff.vy > 48'sd0) ||
                           (py_e < wall_n && l1_item_ff.vy < 48'sd0));
         l2_refl_ff[2] <= cfg_ff.gravity_enable && l1_item_ff.pz <= 48'sd0 && vz2 <= 48'sd0;
      end
   end

   // damped reflection: magnitude times 0.92, then sign flip
   logic [63:0] l3_prod_ff [3];
   fix_type     l3_v_ff    [3];
   logic [2:0]  l3_refl_ff;
   fix_type     l4_v_ff    [3];

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 3; i++) begin
            l3_prod_ff[i] <= 64'(mag48(l2_v_ff[i])) * 64'(DAMP_Q16);
            l3_v_ff[i]    <= l2_v_ff[i];
         end
         l3_refl_ff <= l2_refl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 3; i++) begin
            if (!l3_refl_ff[i]) l4_v_ff[i] <= l3_v_ff[i];
            else if (l3_v_ff[i][47]) l4_v_ff[i] <= $signed(l3_prod_ff[i][63:16]);
            else l4_v_ff[i] <= -$signed(l3_prod_ff[i][63:16]);
         end
      end
   end

   // ---------------- drag: speed ----------------
   logic [95:0] sq [3];
   logic [95:0] ss_ff;
   logic [47:0] spd;

   for (genvar i = 0; i < 3; i++) begin : g_sq
      pfi_mul #(.A_W(48), .B_W(48)) u_sq (
         .clock(clock), .en(advance), .a(mag48(l4_v_ff[i])), .b(mag48(l4_v_ff[i])),
         .prod(sq[i]));
   end

   always_ff @(posedge clock) begin
      if (advance) ss_ff <= sq[0] + sq[1] + sq[2];
   end

   pfi_sqrt #(.R_W(96)) u_sqrt (.clock(clock), .en(advance), .rad(ss_ff), .root(spd));

   // drag factor k = speed * coeff, saturated to 64 bits
   logic [94:0] kprod;
   logic [63:0] k_ff;

   pfi_mul #(.A_W(48), .B_W(47)) u_kmul (
      .clock(clock), .en(advance), .a(spd), .b(cfg_ff.drag_coeff), .prod(kprod));

   always_ff @(posedge clock) begin
      if (advance) k_ff <= (|kprod[94:80]) ? '1 : kprod[79:16];
   end

   // lane velocities wait for k
   logic [143:0] l4_v_pk, v58_pk, v60_pk;
   fix_type      v58 [3];
   fix_type      v60 [3];

   assign l4_v_pk = {l4_v_ff[2], l4_v_ff[1], l4_v_ff[0]};

   pfi_delay #(.W(144), .DEPTH(T_V58)) u_v58_dly (
      .clock(clock), .en(advance), .d_in(l4_v_pk), .d_out(v58_pk));
   pfi_delay #(.W(144), .DEPTH(2)) u_v60_dly (
      .clock(clock), .en(advance), .d_in(v58_pk), .d_out(v60_pk));

   logic [111:0] dprod [3];
   fix_type      drag_v_ff [3];

   for (genvar i = 0; i < 3; i++) begin : g_drag
      assign v58[i] = v58_pk[i*48 +: 48];
      assign v60[i] = v60_pk[i*48 +: 48];
      pfi_mul #(.A_W(48), .B_W(64)) u_dmul (
         .clock(clock), .en(advance), .a(mag48(v58[i])), .b(k_ff), .prod(dprod[i]));
   end

   // each velocity pulled toward zero by its clamped drag step
   always_ff @(posedge clock) begin
      logic [49:0]        dc;
      logic signed [50:0] dd;
      if (advance) begin
         for (int i = 0; i < 3; i++) begin
            dc = (dprod[i][111:16] > 96'(STEP_CLAMP)) ? STEP_CLAMP : dprod[i][65:16];
            dd = $signed({1'b0, dc});
            if (v60[i] > 48'sd0) drag_v_ff[i] <= sat51(ext51(v60[i]) - dd);
            else if (v60[i] < 48'sd0) drag_v_ff[i] <= sat51(ext51(v60[i]) + dd);
            else drag_v_ff[i] <= v60[i];
         end
      end
   end

   logic [143:0] drag_pk, vd83_pk;
   assign drag_pk = {drag_v_ff[2], drag_v_ff[1], drag_v_ff[0]};

   pfi_delay #(.W(144), .DEPTH(T_DRAG)) u_drag_dly (
      .clock(clock), .en(advance), .d_in(drag_pk), .d_out(vd83_pk));

   // ---------------- space branch ----------------
   // t = min(|y| / earth radius, 32768), den = 1 + t^2, dv = g / den
   logic [63:0] num1;
   logic [46:0] radius;
   logic        ovf0, ovf32;
   logic [31:0] q1;
   logic [31:0] t_ff;
   logic [63:0] tt;
   logic [46:0] den_ff;
   logic [46:0] q2;

   assign num1   = {mag48(item0_ff.py), 16'h0000};
   assign radius = (cfg_ff.earth_radius == '0) ? 47'd1 : cfg_ff.earth_radius;
   assign ovf0   = {15'h0000, num1[63:32]} >= radius;   // quotient beyond 32 bits

   pfi_div #(.N_W(64), .D_W(47), .Q_W(32)) u_div_t (
      .clock(clock), .en(advance), .num(num1), .den(radius), .quo(q1));

   pfi_delay #(.W(1), .DEPTH(T_DIV1)) u_ovf_dly (
      .clock(clock), .en(advance), .d_in(ovf0), .d_out(ovf32));

   always_ff @(posedge clock) begin
      if (advance) t_ff <= (ovf32 || q1 > 32'h8000_0000) ? 32'h8000_0000 : q1;
   end

   pfi_mul #(.A_W(32), .B_W(32)) u_tsq (
      .clock(clock), .en(advance), .a(t_ff), .b(t_ff), .prod(tt));

   always_ff @(posedge clock) begin
      if (advance) den_ff <= 47'd65536 + tt[62:16];
   end

   pfi_div #(.N_W(63), .D_W(47), .Q_W(47)) u_div_g (
      .clock(clock), .en(advance), .num({cfg_ff.gravity_dv, 16'h0000}), .den(den_ff),
      .quo(q2));

   // ---------------- merge ----------------
   fix_type vf_ff [3];
   fix_type vz_space;

   assign vz_space = sat51(ext51(base83.item.vz) - $signed({4'b0, q2}));

   always_ff @(posedge clock) begin
      if (advance) begin
         if (base83.space) begin
            vf_ff[0] <= base83.item.vx;
            vf_ff[1] <= base83.item.vy;
            vf_ff[2] <= vz_space;
         end else begin
            vf_ff[0] <= vd83_pk[47:0];
            vf_ff[1] <= vd83_pk[95:48];
            vf_ff[2] <= vd83_pk[143:96];
         end
      end
   end

   // ---------------- position ----------------
   logic [143:0] vf_pk, vf86_pk;
   fix_type      vf86 [3];
   logic [94:0]  pprod [3];
   fix_type      pos86 [3];

   assign vf_pk    = {vf_ff[2], vf_ff[1], vf_ff[0]};
   assign pos86[0] = base86.item.px;
   assign pos86[1] = base86.item.py;
   assign pos86[2] = base86.item.pz;

   pfi_delay #(.W(144), .DEPTH(2)) u_vf_dly (
      .clock(clock), .en(advance), .d_in(vf_pk), .d_out(vf86_pk));

   for (genvar i = 0; i < 3; i++) begin : g_pos
      assign vf86[i] = vf86_pk[i*48 +: 48];
      pfi_mul #(.A_W(48), .B_W(47)) u_pmul (
         .clock(clock), .en(advance), .a(mag48(vf_ff[i])), .b(cfg_ff.time_step),
         .prod(pprod[i]));
   end

   // response register
   logic [TAG_W-1:0] out_idx_ff;
   fix_type          out_pos_ff [3];
   fix_type          out_vel_ff [3];

   always_ff @(posedge clock) begin
      logic [49:0]        pc;
      logic signed [50:0] pd;
      if (advance) begin
         out_idx_ff <= base86.item.idx;
         for (int i = 0; i < 3; i++) begin
            pc = (pprod[i][94:16] > 79'(STEP_CLAMP)) ? STEP_CLAMP : pprod[i][65:16];
            pd = $signed({1'b0, pc});
            out_vel_ff[i] <= vf86[i];
            if (vf86[i] > 48'sd0) out_pos_ff[i] <= sat51(ext51(pos86[i]) + pd);
            else if (vf86[i] < 48'sd0) out_pos_ff[i] <= sat51(ext51(pos86[i]) - pd);
            else out_pos_ff[i] <= pos86[i];
         end
      end
   end

   assign rsp_ch.valid     = valid_ff[LAT-1];
   assign rsp_ch.out_index = out_idx_ff;
   assign rsp_ch.new_pos_x = out_pos_ff[0];
   assign rsp_ch.new_pos_y = out_pos_ff[1];
   assign rsp_ch.new_pos_z = out_pos_ff[2];
   assign rsp_ch.new_vel_x = out_vel_ff[0];
   assign rsp_ch.new_vel_y = out_vel_ff[1];
   assign rsp_ch.new_vel_z = out_vel_ff[2];
endmodule
